### design/bpa_pkg.sv
package bpa_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int CNT_W      = PAGE_W + 1;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int ROWS       = MAX_PAGES / WORD_W;
  localparam int ROW_W      = PAGE_W - BIT_W;
  localparam int NWORD_W    = ROW_W + 1;
  localparam int ADDR_W     = 24;
  localparam int PAGE_SHIFT = 12;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MARK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TEST  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_MARK,
    OP_TEST,
    OP_RANGE
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RMW,
    B_SCAN,
    B_MARK,
    B_FINISH
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  want;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } queue_out_t;

  // Number of consecutive ones counted upwards from bit 0.
  function automatic logic [BIT_W:0] low_ones(input logic [WORD_W-1:0] v);
    logic [BIT_W:0] cnt;
    cnt = (BIT_W + 1)'(WORD_W);
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        cnt = (BIT_W + 1)'(i);
      end
    end
    return cnt;
  endfunction

  // Number of consecutive ones counted downwards from the top bit.
  function automatic logic [BIT_W:0] high_ones(input logic [WORD_W-1:0] v);
    logic [BIT_W:0] cnt;
    cnt = (BIT_W + 1)'(WORD_W);
    for (int i = 0; i < WORD_W; i++) begin
      if (!v[i]) begin
        cnt = (BIT_W + 1)'(WORD_W - 1 - i);
      end
    end
    return cnt;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  // Bit j is set when the len bits ending at j are all set; len is 1 to WORD_W.
  function automatic logic [WORD_W-1:0] window_fit(input logic [WORD_W-1:0] v,
                                                   input logic [BIT_W:0]    len);
    logic [WORD_W-1:0] p [BIT_W+1];
    logic [WORD_W-1:0] acc;
    p[0] = v;
    for (int k = 1; k <= BIT_W; k++) begin
      p[k] = p[k-1] & (p[k-1] << (1 << (k - 1)));
    end
    acc = '1;
    for (int k = 0; k <= BIT_W; k++) begin
      if (len[k]) begin
        acc = acc & (p[k] << (len & (BIT_W + 1)'((1 << k) - 1)));
      end
    end
    return acc;
  endfunction

endpackage

### design/bitmap_page_allocator_unit.sv
// An allocation searches the map word by word and then marks each word of the run it found;
// the search reads one 32-page word a cycle.
// The back end works on one request at a time; a two-entry queue in front keeps accepting until it is full.
// Reset: pages_in_use returns to 4096 and every page reads as used at once through
// per-row flags, so there is no clearing pass.
module bitmap_page_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpa_pkg::CNT_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpa_pkg::MODE_W-1:0]    mode,
  input  logic [bpa_pkg::ADDR_W-1:0]    address,
  input  logic [bpa_pkg::CNT_W-1:0]     run_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bpa_pkg::ADDR_W-1:0]    start_address,
  output logic                          page_used,
  output logic [bpa_pkg::STATUS_W-1:0]  status
);

  logic [bpa_pkg::CNT_W-1:0] pages_in_use;
  logic [bpa_pkg::CNT_W-1:0] limit;
  bpa_pkg::queue_out_t       head;
  logic                      pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= bpa_pkg::CNT_W'(bpa_pkg::MAX_PAGES);
    end else if (cfg_valid && cfg_ready) begin
      pages_in_use <= cfg_data;
    end
  end

  assign limit = (pages_in_use > bpa_pkg::CNT_W'(bpa_pkg::MAX_PAGES)) ?
                 bpa_pkg::CNT_W'(bpa_pkg::MAX_PAGES) : pages_in_use;

  bpa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .address    (address),
    .run_length (run_length),
    .limit      (limit),
    .head       (head),
    .pop        (pop)
  );

  bpa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .limit         (limit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .start_address (start_address),
    .page_used     (page_used),
    .status        (status)
  );

endmodule

### design/bpa_front.sv
module bpa_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bpa_pkg::MODE_W-1:0]   mode,
  input  logic [bpa_pkg::ADDR_W-1:0]   address,
  input  logic [bpa_pkg::CNT_W-1:0]    run_length,
  input  logic [bpa_pkg::CNT_W-1:0]    limit,
  output bpa_pkg::queue_out_t          head,
  input  logic                         pop
);

  bpa_pkg::req_t  entry [2];
  bpa_pkg::req_t  req_in;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           take;

  always_comb begin
    req_in.page = address[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
    req_in.want = (run_length == '0) ? bpa_pkg::CNT_W'(1) : run_length;
    req_in.op   = bpa_pkg::OP_ALLOC;
    if (mode != bpa_pkg::MODE_ALLOC && {1'b0, req_in.page} >= limit) begin
      req_in.op = bpa_pkg::OP_RANGE;
    end else begin
      unique case (mode)
        bpa_pkg::MODE_ALLOC: req_in.op = bpa_pkg::OP_ALLOC;
        bpa_pkg::MODE_FREE:  req_in.op = bpa_pkg::OP_FREE;
        bpa_pkg::MODE_MARK:  req_in.op = bpa_pkg::OP_MARK;
        bpa_pkg::MODE_TEST:  req_in.op = bpa_pkg::OP_TEST;
        default:             req_in.op = bpa_pkg::OP_ALLOC;
      endcase
    end
  end

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign take       = pop && head.valid;
  assign head.valid = (count != 2'd0);
  assign head.req   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= req_in;
    end
  end

endmodule

### design/bpa_back.sv
module bpa_back (
  input  logic                          clk,
  input  logic                          rst,
  input  bpa_pkg::queue_out_t           head,
  output logic                          pop,
  input  logic [bpa_pkg::CNT_W-1:0]     limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bpa_pkg::ADDR_W-1:0]    start_address,
  output logic                          page_used,
  output logic [bpa_pkg::STATUS_W-1:0]  status
);

  localparam int WW = bpa_pkg::WORD_W;
  localparam int BW = bpa_pkg::BIT_W;
  localparam int RW = bpa_pkg::ROW_W;
  localparam int PW = bpa_pkg::PAGE_W;
  localparam int CW = bpa_pkg::CNT_W;

  // Used map: one bit per page, a row per word; a row never written reads as all used.
  logic [WW-1:0]  mem [bpa_pkg::ROWS];
  logic           row_ok [bpa_pkg::ROWS];

  bpa_pkg::state_t state;
  bpa_pkg::state_t state_next;
  bpa_pkg::req_t   cur;

  logic                         rd_en;
  logic [RW-1:0]                rd_addr;
  logic [WW-1:0]                rd_data;
  logic                         rd_ok;
  logic                         wr_en;
  logic [RW-1:0]                wr_addr;
  logic [WW-1:0]                wr_data;

  logic [RW-1:0]                proc_idx;
  logic [CW-1:0]                run;
  logic [PW-1:0]                run_start;
  logic [PW-1:0]                mark_lo;
  logic [PW-1:0]                mark_hi;
  logic [RW-1:0]                mark_row;
  logic [PW-1:0]                res_page;
  logic                         res_used;
  logic [bpa_pkg::STATUS_W-1:0] res_status;

  logic [WW-1:0]                eff;
  logic [bpa_pkg::NWORD_W-1:0]  nwords;
  logic                         last;
  logic [PW-1:0]                base;
  logic [CW-1:0]                room;
  logic [WW-1:0]                lim_mask;
  logic [WW-1:0]                free;
  logic [BW:0]                  t_cnt;
  logic [BW:0]                  h_cnt;
  logic [CW:0]                  lead_sum;
  logic                         lead_hit;
  logic                         short_run;
  logic [WW-1:0]                win;
  logic                         in_hit;
  logic                         hit;
  logic [PW-1:0]                in_start;
  logic [PW-1:0]                found_start;
  logic [PW-1:0]                found_end;
  logic [CW-1:0]                run_next;
  logic [PW-1:0]                run_start_next;
  logic [BW-1:0]                lo_bit;
  logic [BW-1:0]                hi_bit;
  logic [WW-1:0]                range_mask;
  logic [WW-1:0]                page_bit;
  logic                         slot_free;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
      for (int i = 0; i < bpa_pkg::ROWS; i++) begin
        row_ok[i] <= 1'b0;
      end
    end else begin
      if (rd_en) begin
        rd_ok <= row_ok[rd_addr];
      end
      if (wr_en) begin
        row_ok[wr_addr] <= 1'b1;
      end
    end
  end

  assign eff = rd_ok ? rd_data : '1;

  always_comb begin
    nwords    = bpa_pkg::NWORD_W'(({1'b0, limit} + (CW + 1)'(WW - 1)) >> BW);
    last      = (proc_idx == RW'(nwords - bpa_pkg::NWORD_W'(1)));
    base      = {proc_idx, {BW{1'b0}}};
    room      = limit - {1'b0, base};
    lim_mask  = (room >= CW'(WW)) ? '1 : ((WW'(1) << room[BW-1:0]) - WW'(1));
    free      = ~eff & lim_mask;
    t_cnt     = bpa_pkg::low_ones(free);
    h_cnt     = bpa_pkg::high_ones(free);
    lead_sum  = {1'b0, run} + (CW + 1)'(t_cnt);
    lead_hit  = (lead_sum >= {1'b0, cur.want});
    short_run = (cur.want <= CW'(WW));
    win       = bpa_pkg::window_fit(free, cur.want[BW:0]);
    in_hit    = short_run && (win != '0);
    hit       = lead_hit || in_hit;
    in_start  = base + PW'(bpa_pkg::lowest_set(win)) + PW'(1) - cur.want[PW-1:0];
    found_start = lead_hit ? run_start : in_start;
    found_end   = found_start + cur.want[PW-1:0] - PW'(1);
    if (t_cnt == (BW + 1)'(WW)) begin
      run_next       = run + CW'(WW);
      run_start_next = run_start;
    end else begin
      run_next       = CW'(h_cnt);
      run_start_next = base + PW'(WW) - PW'(h_cnt);
    end
    lo_bit     = (mark_row == mark_lo[PW-1:BW]) ? mark_lo[BW-1:0] : '0;
    hi_bit     = (mark_row == mark_hi[PW-1:BW]) ? mark_hi[BW-1:0] : BW'(WW - 1);
    range_mask = ({WW{1'b1}} << lo_bit) & ({WW{1'b1}} >> (BW'(WW - 1) - hi_bit));
    page_bit   = WW'(1) << cur.page[BW-1:0];
    slot_free  = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bpa_pkg::B_IDLE: begin
        if (head.valid) begin
          if (head.req.op == bpa_pkg::OP_ALLOC) begin
            state_next = (nwords == '0) ? bpa_pkg::B_FINISH : bpa_pkg::B_SCAN;
          end else if (head.req.op == bpa_pkg::OP_RANGE) begin
            state_next = bpa_pkg::B_FINISH;
          end else begin
            state_next = bpa_pkg::B_RMW;
          end
        end
      end
      bpa_pkg::B_RMW: state_next = bpa_pkg::B_FINISH;
      bpa_pkg::B_SCAN: begin
        if (hit) begin
          state_next = bpa_pkg::B_MARK;
        end else if (last) begin
          state_next = bpa_pkg::B_FINISH;
        end
      end
      bpa_pkg::B_MARK: begin
        if (mark_row == mark_hi[PW-1:BW]) begin
          state_next = bpa_pkg::B_FINISH;
        end
      end
      bpa_pkg::B_FINISH: begin
        if (slot_free) begin
          state_next = bpa_pkg::B_IDLE;
        end
      end
      default: state_next = bpa_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      bpa_pkg::B_IDLE: begin
        pop     = head.valid;
        rd_en   = head.valid;
        rd_addr = (head.req.op == bpa_pkg::OP_ALLOC) ? '0 : head.req.page[PW-1:BW];
      end
      bpa_pkg::B_RMW: begin
        wr_en   = (cur.op == bpa_pkg::OP_FREE) || (cur.op == bpa_pkg::OP_MARK);
        wr_addr = cur.page[PW-1:BW];
        wr_data = (cur.op == bpa_pkg::OP_FREE) ? (eff & ~page_bit) : (eff | page_bit);
      end
      bpa_pkg::B_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = hit ? found_start[PW-1:BW] : proc_idx + RW'(1);
      end
      bpa_pkg::B_MARK: begin
        wr_en   = 1'b1;
        wr_addr = mark_row;
        wr_data = eff | range_mask;
        rd_en   = 1'b1;
        rd_addr = mark_row + RW'(1);
      end
      bpa_pkg::B_FINISH: begin
        pop = 1'b0;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpa_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bpa_pkg::B_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bpa_pkg::B_IDLE: begin
        if (head.valid) begin
          cur       <= head.req;
          proc_idx  <= '0;
          run       <= '0;
          run_start <= '0;
          res_page  <= '0;
          res_used  <= 1'b0;
          if (head.req.op == bpa_pkg::OP_RANGE) begin
            res_status <= bpa_pkg::ST_RANGE;
          end else if (head.req.op == bpa_pkg::OP_ALLOC && nwords == '0) begin
            res_status <= bpa_pkg::ST_OOM;
          end else begin
            res_status <= bpa_pkg::ST_OK;
          end
        end
      end
      bpa_pkg::B_RMW: begin
        if (cur.op == bpa_pkg::OP_TEST) begin
          res_used <= eff[cur.page[BW-1:0]];
        end
      end
      bpa_pkg::B_SCAN: begin
        if (hit) begin
          mark_lo  <= found_start;
          mark_hi  <= found_end;
          mark_row <= found_start[PW-1:BW];
          res_page <= found_start;
        end else begin
          run       <= run_next;
          run_start <= run_start_next;
          proc_idx  <= proc_idx + RW'(1);
          if (last) begin
            res_status <= bpa_pkg::ST_OOM;
          end
        end
      end
      bpa_pkg::B_MARK: begin
        mark_row <= mark_row + RW'(1);
      end
      bpa_pkg::B_FINISH: begin
        if (slot_free) begin
          start_address <= {res_page, {bpa_pkg::PAGE_SHIFT{1'b0}}};
          page_used     <= res_used;
          status        <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  a_write_only_when_updating: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == bpa_pkg::B_RMW || state == bpa_pkg::B_MARK))
    else $error("map written outside an update step");

  a_scan_is_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == bpa_pkg::B_SCAN || state == bpa_pkg::B_MARK) |-> cur.op == bpa_pkg::OP_ALLOC)
    else $error("search running for a request that is not an allocation");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == bpa_pkg::B_FINISH && slot_free) |=> out_valid)
    else $error("finished request did not reach the output register");

  a_fail_has_zero_address: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != bpa_pkg::ST_OK) |-> (start_address == '0 && !page_used))
    else $error("failed request carries an address or a used flag");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == bpa_pkg::B_IDLE)
    else $error("queue popped while a request is in progress");

endmodule

### test/tb_bitmap_page_allocator_unit.sv
module tb_bitmap_page_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  class page_ledger;
    typedef struct {
      logic [ADDR_W-1:0]   base_addr;
      logic                used;
      logic [STATUS_W-1:0] code;
    } alloc_reply_t;

    bit               page_taken [MAX_PAGES];
    logic [CNT_W-1:0] pages_reg;
    alloc_reply_t     replies [$];
    int               errors;

    function new();
      foreach (page_taken[i]) page_taken[i] = 1'b1;
      pages_reg = CNT_W'(4096);
      errors = 0;
    endfunction

    function void set_pages(logic [CNT_W-1:0] value);
      pages_reg = value;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    function void note_request(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] addr,
                               logic [CNT_W-1:0] len);
      alloc_reply_t r;
      int lim;
      int pg;
      int need;
      int run;
      int first;
      lim = (pages_reg > MAX_PAGES) ? MAX_PAGES : int'(pages_reg);
      pg = int'(addr >> PAGE_SHIFT);
      r.base_addr = '0;
      r.used = 1'b0;
      r.code = ST_OK;
      if (m == MODE_ALLOC) begin
        need = (len == 0) ? 1 : int'(len);
        run = 0;
        first = -1;
        for (int i = 0; i < lim && first < 0; i++) begin
          run = page_taken[i] ? 0 : run + 1;
          if (run >= need) first = i + 1 - need;
        end
        if (first < 0) begin
          r.code = ST_OOM;
        end else begin
          for (int k = first; k < first + need; k++) page_taken[k] = 1'b1;
          r.base_addr = ADDR_W'(first << PAGE_SHIFT);
        end
      end else if (pg >= lim) begin
        r.code = ST_RANGE;
      end else if (m == MODE_FREE) begin
        page_taken[pg] = 1'b0;
      end else if (m == MODE_MARK) begin
        page_taken[pg] = 1'b1;
      end else begin
        r.used = page_taken[pg];
      end
      replies.push_back(r);
    endfunction

    function void check_reply(logic [ADDR_W-1:0] got_addr, logic got_used,
                              logic [STATUS_W-1:0] got_code);
      alloc_reply_t exp_r;
      if (replies.size() == 0) begin
        errors++;
        if (errors <= 200)
          $display("%0t: reply with none expected, actual start %h used %b status %0d",
                   $time, got_addr, got_used, got_code);
        return;
      end
      exp_r = replies.pop_front();
      if (got_addr !== exp_r.base_addr) begin
        errors++;
        if (errors <= 200)
          $display("%0t: start_address expected %h actual %h",
                   $time, exp_r.base_addr, got_addr);
      end
      if (got_used !== exp_r.used) begin
        errors++;
        if (errors <= 200)
          $display("%0t: page_used expected %b actual %b", $time, exp_r.used, got_used);
      end
      if (got_code !== exp_r.code) begin
        errors++;
        if (errors <= 200)
          $display("%0t: status expected %0d actual %0d", $time, exp_r.code, got_code);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CNT_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   mode = MODE_ALLOC;
  logic [ADDR_W-1:0]   address = '0;
  logic [CNT_W-1:0]    run_length = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ADDR_W-1:0]   start_address;
  logic                page_used;
  logic [STATUS_W-1:0] status;

  page_ledger ledger = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cur_limit = 4096;
  int sent_items = 0;

  bitmap_page_allocator_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .address       (address),
    .run_length    (run_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .start_address (start_address),
    .page_used     (page_used),
    .status        (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      ledger.check_reply(start_address, page_used, status);
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] addr,
                      input logic [CNT_W-1:0] len);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    address    <= addr;
    run_length <= len;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(m, addr, len);
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_pages(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ledger.set_pages(value);
    cur_limit = (value > MAX_PAGES) ? MAX_PAGES : int'(value);
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [PAGE_W-1:0] pg;
    if (cur_limit > 0 && $urandom_range(9) != 0) begin
      pg = PAGE_W'($urandom_range(0, cur_limit - 1));
    end else begin
      pg = PAGE_W'($urandom);
    end
    return {pg, PAGE_SHIFT'($urandom)};
  endfunction

  function automatic logic [CNT_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return CNT_W'($urandom_range(0, 4));
    if (roll < 90) return CNT_W'($urandom_range(5, 32));
    if (roll < 97) return CNT_W'($urandom);
    return CNT_W'(4096);
  endfunction

  // One item in four frees a short block of pages and then asks for a run of about that size.
  task automatic random_item();
    int roll;
    int n;
    int base;
    roll = $urandom_range(99);
    if (roll < 25) begin
      n = $urandom_range(1, 10);
      base = (cur_limit > 0) ? $urandom_range(0, cur_limit - 1) : 0;
      for (int j = 0; j < n; j++) begin
        send(MODE_FREE, {PAGE_W'(base + j), PAGE_SHIFT'($urandom)}, CNT_W'($urandom));
      end
      send(MODE_ALLOC, ADDR_W'($urandom), CNT_W'($urandom_range(0, n + 1)));
    end else if (roll < 45) begin
      send(MODE_ALLOC, ADDR_W'($urandom), pick_length());
    end else if (roll < 63) begin
      send(MODE_FREE, pick_address(), CNT_W'($urandom));
    end else if (roll < 82) begin
      send(MODE_TEST, pick_address(), CNT_W'($urandom));
    end else begin
      send(MODE_MARK, pick_address(), CNT_W'($urandom));
    end
  endtask

  initial begin
    int pages_list [9];
    int goal;
    pages_list = '{64, 4097, 100, 37, 8191, 160, 9, 1, 0};
    pages_list[8] = $urandom_range(0, 8191);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(MODE_ALLOC, 24'h000000, 13'd0);
    send(MODE_TEST,  24'h000FFF, 13'd0);
    send(MODE_TEST,  24'hFFFFFF, 13'h1FFF);
    send(MODE_FREE,  24'h000ABC, 13'd0);
    send(MODE_FREE,  24'h001000, 13'd0);
    send(MODE_ALLOC, 24'hFFFFFF, 13'd1);
    send(MODE_ALLOC, 24'h000000, 13'd0);
    send(MODE_ALLOC, 24'h000000, 13'd2);
    send(MODE_FREE,  24'hFFF000, 13'd0);
    send(MODE_FREE,  24'hFFE123, 13'd0);
    send(MODE_ALLOC, 24'h000000, 13'd2);
    send(MODE_FREE,  24'h00A000, 13'd0);
    send(MODE_TEST,  24'h00A000, 13'd0);
    send(MODE_MARK,  24'h00A000, 13'd0);
    send(MODE_TEST,  24'h00A000, 13'd0);
    send(MODE_ALLOC, 24'h000000, 13'd4096);
    send(MODE_ALLOC, 24'h000000, 13'h1FFF);
    drain();
    set_pages(13'd0);
    send(MODE_ALLOC, 24'h000000, 13'd1);
    send(MODE_FREE,  24'h000000, 13'd0);
    send(MODE_MARK,  24'h000000, 13'd0);
    send(MODE_TEST,  24'h000000, 13'd0);
    drain();
    set_pages(13'd3);
    send(MODE_FREE,  24'h001000, 13'd0);
    send(MODE_FREE,  24'h002000, 13'd0);
    send(MODE_ALLOC, 24'h000000, 13'd3);
    send(MODE_ALLOC, 24'h000000, 13'd2);
    send(MODE_TEST,  24'h003000, 13'd0);

    for (int p = 0; p < 9; p++) begin
      drain();
      set_pages(CNT_W'(pages_list[p]));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      goal = sent_items + 105;
      while (sent_items < goal) random_item();
    end

    drain();
    repeat (300) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
